// File: hdl/kimt_pkg.sv
package kimt_pkg;

   localparam int FIELD_W = 64;
   localparam int ENTRY_W = 2 * FIELD_W;

   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_GOC   = 3'd1;
   localparam logic [2:0] OP_SET   = 3'd2;
   localparam logic [2:0] OP_UNREG = 3'd3;
   localparam logic [2:0] OP_ITER  = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_INVALID      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
   localparam logic [2:0] ST_EXISTS       = 3'd3;
   localparam logic [2:0] ST_FULL         = 3'd4;
   localparam logic [2:0] ST_ALLOC_FAILED = 3'd5;
   localparam logic [2:0] ST_EMPTY        = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_MOVE = 5'b00100,
      S_WB   = 5'b01000,
      S_ITER = 5'b10000
   } state_type;

endpackage

// File: hdl/kimt_ram.sv
module kimt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/key_id_map_table.sv
// Key to id map: up to MAX_ENTRIES pairs of nonzero 64-bit keys and ids,
// packed in one single-port-read RAM, searched linearly.
// Request channel: drive req_* with start high; the beat is taken at the
// edge where start is high and busy is low. busy stays high until the
// operation has issued its last result.
// Result channel: each result is on rsp_* for exactly one cycle, marked by
// rsp_valid; rsp_last flags the final result of the request. The receiver
// cannot stall, so results are never held.
// Rejected requests (bad opcode, zero key or set value) and iterate over
// an empty table answer in the cycle after the request. Get, get-or-create
// and set scan the table, reading one stored entry per cycle from the RAM,
// which has a registered read. Unregister adds the MOVE and WB states for
// reading the tail entry and writing it into the hole. Iterate streams one
// entry per cycle. busy drops in the cycle that carries the last result,
// so the next request can be taken at the edge that ends it.
// Reset clears the entry count; RAM contents need no clearing, since only
// entries below the count are ever used.
module key_id_map_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value_in,
   input  logic [63:0] req_fresh_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_key_out,
   output logic [63:0] rsp_value_out,
   output logic        rsp_last
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int FW = kimt_pkg::FIELD_W;

   kimt_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] hole_ff, hole_in;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_live_ff, rd_live_in;
   logic [2:0]    op_ff;
   logic [FW-1:0] key_ff;
   logic [FW-1:0] val_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [FW-1:0] rsp_key_ff, rsp_key_in;
   logic [FW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                          accept;
   logic                          full;
   logic                          hit;
   logic [CW-1:0]                 tail_cnt;
   logic [IW-1:0]                 tail;
   logic [IW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [kimt_pkg::ENTRY_W-1:0] wr_data;
   logic [kimt_pkg::ENTRY_W-1:0] rd_data;
   logic [FW-1:0]                 key_rd;
   logic [FW-1:0]                 val_rd;

   kimt_ram #(
      .WIDTH (kimt_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != kimt_pkg::S_IDLE);
   assign accept   = start && !busy;
   assign full     = (count_ff == CW'(MAX_ENTRIES));
   assign tail_cnt = count_ff - CW'(1);
   assign tail     = tail_cnt[IW-1:0];
   assign key_rd   = rd_data[kimt_pkg::ENTRY_W-1:FW];
   assign val_rd   = rd_data[FW-1:0];
   assign hit      = rd_live_ff && (key_rd == key_ff);

   // Read address: entry 0 while idle so a scan starts on accept
   always_comb begin
      rd_addr    = '0;
      rd_live_in = 1'b0;
      unique case (state_ff)
         kimt_pkg::S_IDLE: begin
            rd_live_in = accept && (count_ff != '0);
         end
         kimt_pkg::S_SCAN, kimt_pkg::S_ITER: begin
            rd_addr    = ptr_ff[IW-1:0];
            rd_live_in = (ptr_ff < count_ff);
         end
         kimt_pkg::S_MOVE, kimt_pkg::S_WB: begin
            rd_addr = tail;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff + CW'(1);
      hole_in       = hole_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = {key_ff, val_ff};
      rsp_valid_in  = 1'b0;
      rsp_status_in = kimt_pkg::ST_OK;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         kimt_pkg::S_IDLE: begin
            ptr_in = CW'(1);
            if (accept) begin
               if (req_opcode > kimt_pkg::OP_ITER
                   || (req_opcode != kimt_pkg::OP_ITER && req_key == '0)
                   || (req_opcode == kimt_pkg::OP_SET && req_value_in == '0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = kimt_pkg::ST_INVALID;
               end else if (req_opcode == kimt_pkg::OP_ITER) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = kimt_pkg::ST_EMPTY;
                  end else begin
                     state_in = kimt_pkg::S_ITER;
                  end
               end else begin
                  state_in = kimt_pkg::S_SCAN;
               end
            end
         end

         kimt_pkg::S_SCAN: begin
            if (hit) begin
               state_in     = kimt_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               unique case (op_ff) inside
                  kimt_pkg::OP_GET, kimt_pkg::OP_GOC: begin
                     rsp_value_in = val_rd;
                  end
                  kimt_pkg::OP_SET: begin
                     rsp_status_in = kimt_pkg::ST_EXISTS;
                  end
                  default: begin
                     // unregister: hold the result until the tail moves in
                     rsp_valid_in = 1'b0;
                     hole_in      = rd_idx_ff;
                     state_in     = kimt_pkg::S_MOVE;
                  end
               endcase
            end else if (!rd_live_ff) begin
               state_in     = kimt_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               unique case (op_ff) inside
                  kimt_pkg::OP_GOC, kimt_pkg::OP_SET: begin
                     if (full) begin
                        rsp_status_in = kimt_pkg::ST_FULL;
                     end else if (val_ff == '0) begin
                        rsp_status_in = kimt_pkg::ST_ALLOC_FAILED;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (op_ff == kimt_pkg::OP_GOC) begin
                           rsp_value_in = val_ff;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = kimt_pkg::ST_NOT_FOUND;
                  end
               endcase
            end
         end

         kimt_pkg::S_MOVE: begin
            state_in = kimt_pkg::S_WB;
         end

         kimt_pkg::S_WB: begin
            // move the tail entry into the hole and drop the tail
            wr_en        = 1'b1;
            wr_addr      = hole_ff;
            wr_data      = rd_data;
            count_in     = tail_cnt;
            rsp_valid_in = 1'b1;
            state_in     = kimt_pkg::S_IDLE;
         end

         kimt_pkg::S_ITER: begin
            if (rd_live_ff) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = key_rd;
               rsp_value_in = val_rd;
               rsp_last_in  = (rd_idx_ff == tail);
               if (rd_idx_ff == tail) begin
                  state_in = kimt_pkg::S_IDLE;
               end
            end else begin
               state_in = kimt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = kimt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kimt_pkg::S_IDLE;
         count_ff     <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      hole_ff       <= hole_in;
      rd_idx_ff     <= rd_addr;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      if (accept) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= (req_opcode == kimt_pkg::OP_GOC) ? req_fresh_id : req_value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode > kimt_pkg::OP_ITER)
      |=> (rsp_valid && rsp_status == kimt_pkg::ST_INVALID && rsp_last))
      else $error("bad opcode not rejected next cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != kimt_pkg::ST_OK)
      |-> (rsp_value_out == '0 && rsp_key_out == '0 && rsp_last))
      else $error("failed result carries data");

   a_count_with_beat: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_valid_ff)
      else $error("entry count changed without a result beat");

   a_iter_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy ##1 rsp_valid))
      else $error("iterate stream broken");
`endif

endmodule

// File: tb/key_id_map_table_test.sv
module key_id_map_table_test;

   localparam int MAX_ENTRIES = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 300;
   localparam int POOL_SIZE = 20;
   localparam int QUIET_FROM = 120;
   localparam int QUIET_TO = 200;

   localparam int PH_FILL = 0;
   localparam int PH_MIX = 1;
   localparam int PH_DRAIN = 2;

   typedef struct {
      logic [2:0]  opcode;
      logic [63:0] key;
      logic [63:0] value_in;
      logic [63:0] fresh_id;
      bit          drain;
   } map_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] key_out;
      logic [63:0] value_out;
      logic        last;
   } map_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic [63:0] req_key = '0;
   logic [63:0] req_value_in = '0;
   logic [63:0] req_fresh_id = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_key_out;
   logic [63:0] rsp_value_out;
   logic        rsp_last;

   map_req_type req_backlog[$];
   map_rsp_type due_rsp[$];
   map_req_type cur_req;

   logic [63:0] shadow_key[MAX_ENTRIES];
   logic [63:0] shadow_id[MAX_ENTRIES];
   int          shadow_count = 0;

   logic [63:0] key_pool[POOL_SIZE];
   int          error_count = 0;
   int          beats_taken = 0;
   int          cycle_count = 0;
   int          random_made = 0;

   key_id_map_table #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .req_value_in(req_value_in),
      .req_fresh_id(req_fresh_id),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_key_out(rsp_key_out),
      .rsp_value_out(rsp_value_out),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void owe_rsp(input logic [2:0] status, input logic [63:0] k,
                                   input logic [63:0] v, input logic fin);
      map_rsp_type r;
      r.status = status;
      r.key_out = k;
      r.value_out = v;
      r.last = fin;
      due_rsp.push_back(r);
   endfunction

   // Update the shadow map for one accepted beat and queue what it owes.
   task automatic apply_map_op(input map_req_type it);
      int idx;
      int tail;
      idx = -1;
      if (it.opcode == kimt_pkg::OP_ITER) begin
         if (shadow_count == 0) begin
            owe_rsp(kimt_pkg::ST_EMPTY, '0, '0, 1'b1);
         end else begin
            for (int i = 0; i < shadow_count; i++)
               owe_rsp(kimt_pkg::ST_OK, shadow_key[i], shadow_id[i],
                       i == shadow_count - 1);
         end
         return;
      end
      if (it.opcode > kimt_pkg::OP_ITER || it.key == '0) begin
         owe_rsp(kimt_pkg::ST_INVALID, '0, '0, 1'b1);
         return;
      end
      for (int i = 0; i < shadow_count; i++)
         if (idx < 0 && shadow_key[i] == it.key) idx = i;
      case (it.opcode)
         kimt_pkg::OP_GET: begin
            if (idx < 0) owe_rsp(kimt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
            else owe_rsp(kimt_pkg::ST_OK, '0, shadow_id[idx], 1'b1);
         end
         kimt_pkg::OP_GOC: begin
            if (idx >= 0) begin
               owe_rsp(kimt_pkg::ST_OK, '0, shadow_id[idx], 1'b1);
            end else if (shadow_count >= MAX_ENTRIES) begin
               owe_rsp(kimt_pkg::ST_FULL, '0, '0, 1'b1);
            end else if (it.fresh_id == '0) begin
               owe_rsp(kimt_pkg::ST_ALLOC_FAILED, '0, '0, 1'b1);
            end else begin
               shadow_key[shadow_count] = it.key;
               shadow_id[shadow_count] = it.fresh_id;
               shadow_count++;
               owe_rsp(kimt_pkg::ST_OK, '0, it.fresh_id, 1'b1);
            end
         end
         kimt_pkg::OP_SET: begin
            if (it.value_in == '0) begin
               owe_rsp(kimt_pkg::ST_INVALID, '0, '0, 1'b1);
            end else if (idx >= 0) begin
               owe_rsp(kimt_pkg::ST_EXISTS, '0, '0, 1'b1);
            end else if (shadow_count >= MAX_ENTRIES) begin
               owe_rsp(kimt_pkg::ST_FULL, '0, '0, 1'b1);
            end else begin
               shadow_key[shadow_count] = it.key;
               shadow_id[shadow_count] = it.value_in;
               shadow_count++;
               owe_rsp(kimt_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         default: begin
            if (idx < 0) begin
               owe_rsp(kimt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               // move the tail entry into the hole
               tail = shadow_count - 1;
               shadow_key[idx] = shadow_key[tail];
               shadow_id[idx] = shadow_id[tail];
               shadow_count = tail;
               owe_rsp(kimt_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
      endcase
   endtask

   task automatic queue_req(input logic [2:0] op, input logic [63:0] k,
                            input logic [63:0] v, input logic [63:0] f,
                            input bit drain);
      map_req_type it;
      it.opcode = op;
      it.key = k;
      it.value_in = v;
      it.fresh_id = f;
      it.drain = drain;
      req_backlog.push_back(it);
   endtask

   // One random beat, weighted by the phase of the fill / churn / empty round.
   task automatic queue_random(input int phase, input bit drain);
      int r;
      logic [2:0]  op;
      logic [63:0] k;
      logic [63:0] v;
      logic [63:0] f;
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      v = rand64();
      f = ($urandom_range(0, 99) < 6) ? '0 : rand64();
      if ($urandom_range(0, 99) < 8) begin
         case ($urandom_range(0, 2))
            0: op = 3'($urandom_range(5, 7));
            1: begin
               op = 3'($urandom_range(0, 3));
               k = '0;
            end
            default: begin
               op = kimt_pkg::OP_SET;
               v = '0;
            end
         endcase
      end else if (phase == PH_FILL) begin
         op = (r < 45) ? kimt_pkg::OP_SET : (r < 90) ? kimt_pkg::OP_GOC :
              kimt_pkg::OP_GET;
      end else if (phase == PH_MIX) begin
         op = (r < 20) ? kimt_pkg::OP_GET : (r < 42) ? kimt_pkg::OP_GOC :
              (r < 62) ? kimt_pkg::OP_SET : (r < 86) ? kimt_pkg::OP_UNREG :
              kimt_pkg::OP_ITER;
         if (r >= 96) k = rand64();
      end else begin
         op = (r < 75) ? kimt_pkg::OP_UNREG : (r < 90) ? kimt_pkg::OP_GET :
              kimt_pkg::OP_ITER;
      end
      queue_req(op, k, v, f, drain);
      random_made++;
   endtask

   initial begin
      // directed corner cases
      queue_req(kimt_pkg::OP_ITER, rand64(), rand64(), rand64(), 1'b0);
      queue_req(kimt_pkg::OP_GET, '0, '1, '1, 1'b0);
      queue_req(kimt_pkg::OP_GET, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_UNREG, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_SET, '1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_SET, '1, '1, '0, 1'b0);
      queue_req(kimt_pkg::OP_SET, '1, 64'h5, '0, 1'b0);
      queue_req(kimt_pkg::OP_GOC, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_GOC, 64'h1, '0, 64'h1, 1'b0);
      queue_req(kimt_pkg::OP_GOC, 64'h1, '0, 64'h77, 1'b0);
      queue_req(kimt_pkg::OP_GOC, 64'h8000_0000_0000_0000, '1, '1, 1'b0);
      queue_req(kimt_pkg::OP_GET, '1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_GET, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_GOC, '0, '0, 64'h3, 1'b0);
      queue_req(kimt_pkg::OP_UNREG, '0, '0, '0, 1'b0);
      queue_req(3'd5, 64'h1, 64'h1, 64'h1, 1'b0);
      queue_req(3'd6, '1, '1, '1, 1'b0);
      queue_req(3'd7, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_ITER, '0, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_UNREG, '1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_ITER, '0, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_UNREG, 64'h1, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_UNREG, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
      queue_req(kimt_pkg::OP_ITER, '1, '1, '1, 1'b0);

      // rounds: fill past full, churn, then empty out
      while (random_made < RANDOM_ITEMS) begin
         foreach (key_pool[i]) begin
            key_pool[i] = rand64();
            if (key_pool[i] == '0) key_pool[i] = 64'h1;
         end
         repeat (26) queue_random(PH_FILL, 1'b0);
         queue_req(kimt_pkg::OP_ITER, rand64(), rand64(), rand64(), 1'b0);
         queue_random(PH_MIX, 1'b1);
         repeat (29) queue_random(PH_MIX, 1'b0);
         repeat (26) queue_random(PH_DRAIN, 1'b0);
         queue_req(kimt_pkg::OP_ITER, rand64(), rand64(), rand64(), 1'b0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || start || due_rsp.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin : drive
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_map_op(cur_req);
            beats_taken++;
         end
         if (!start || !busy) begin
            go = req_backlog.size() != 0;
            // hold until every owed result is back
            if (go && req_backlog[0].drain && due_rsp.size() != 0) go = 0;
            if (go && !(beats_taken >= QUIET_FROM && beats_taken < QUIET_TO) &&
                $urandom_range(0, 99) < 25) go = 0;
            if (go) begin
               cur_req = req_backlog.pop_front();
               req_opcode <= cur_req.opcode;
               req_key <= cur_req.key;
               req_value_in <= cur_req.value_in;
               req_fresh_id <= cur_req.fresh_id;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      map_rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status %0d", rsp_status));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_key_out !== want.key_out)
               flag_mismatch($sformatf("key_out %h, want %h", rsp_key_out, want.key_out));
            if (rsp_value_out !== want.value_out)
               flag_mismatch($sformatf("value_out %h, want %h", rsp_value_out,
                                       want.value_out));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results owed", due_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
